>>> hw/rtl/frx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frx_pkg: shared types and constants for the flow sequence receiver
// Field widths, operation and reply codes, event codes, flow table structs.
// ----------------------------------------------------------------------------
package frx_pkg;

    // Flow table size and index width
    localparam int FLOWS  = 16;
    localparam int FLOW_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    // Field widths
    localparam int OP_W   = 2;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int KEY_W  = ADDR_W + PORT_W;
    localparam int SEQ_W  = 31;
    localparam int ROLL_W = 7;
    localparam int KIND_W = 2;
    localparam int EV_W   = 3;

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    // Packet kinds
    localparam logic [OP_W-1:0] OP_CTRL = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA = 2'd1;
    localparam logic [OP_W-1:0] OP_FIN  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNK  = 2'd3;

    // Reply kinds
    localparam logic [KIND_W-1:0] RPL_NONE = 2'd0;
    localparam logic [KIND_W-1:0] RPL_ACK  = 2'd1;
    localparam logic [KIND_W-1:0] RPL_DROP = 2'd2;

    // Event codes
    localparam logic [EV_W-1:0] EV_DROP_CTRL = 3'd0;
    localparam logic [EV_W-1:0] EV_CTRL      = 3'd1;
    localparam logic [EV_W-1:0] EV_ACK_OLD   = 3'd2;
    localparam logic [EV_W-1:0] EV_DROP_DATA = 3'd3;
    localparam logic [EV_W-1:0] EV_DATA      = 3'd4;
    localparam logic [EV_W-1:0] EV_ACK_DROP  = 3'd5;
    localparam logic [EV_W-1:0] EV_FIN       = 3'd6;
    localparam logic [EV_W-1:0] EV_ERROR     = 3'd7;

    // One incoming packet
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] client_address;
        logic [PORT_W-1:0] client_port;
        logic [SEQ_W-1:0]  sequence_number;
        logic [ROLL_W-1:0] first_roll;
        logic [ROLL_W-1:0] second_roll;
        logic              target_fault;
    } t_item;

    // One reply
    typedef struct packed {
        logic [KIND_W-1:0] reply_kind;
        logic [SEQ_W-1:0]  ack_number;
        logic              data_accepted;
        logic              start_of_file;
        logic [EV_W-1:0]   event_code;
    } t_result;

    // Flow table lookup status
    typedef struct packed {
        logic              hit;
        logic [FLOW_W-1:0] hit_idx;
        logic [SEQ_W-1:0]  expected;
        logic              free_ok;
        logic [FLOW_W-1:0] free_idx;
    } t_lookup;

    // Flow table update command
    typedef struct packed {
        logic              add;
        logic              bump;
        logic              remove;
        logic [FLOW_W-1:0] idx;
        logic [KEY_W-1:0]  key;
        logic [SEQ_W-1:0]  expected;
    } t_update;

endpackage : frx_pkg
`default_nettype wire

>>> hw/rtl/frx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frx_if: valid/ready channels for packets and replies
// One interface per direction, each with source and sink modports.
// ----------------------------------------------------------------------------
interface frx_in_if
    import frx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] client_address;
    logic [PORT_W-1:0] client_port;
    logic [SEQ_W-1:0]  sequence_number;
    logic [ROLL_W-1:0] first_roll;
    logic [ROLL_W-1:0] second_roll;
    logic              target_fault;

    modport source (
        output valid, operation, client_address, client_port, sequence_number,
               first_roll, second_roll, target_fault,
        input  ready
    );
    modport sink (
        input  valid, operation, client_address, client_port, sequence_number,
               first_roll, second_roll, target_fault,
        output ready
    );
endinterface : frx_in_if

interface frx_out_if
    import frx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] reply_kind;
    logic [SEQ_W-1:0]  ack_number;
    logic              data_accepted;
    logic              start_of_file;
    logic [EV_W-1:0]   event_code;

    modport source (
        output valid, reply_kind, ack_number, data_accepted, start_of_file,
               event_code,
        input  ready
    );
    modport sink (
        input  valid, reply_kind, ack_number, data_accepted, start_of_file,
               event_code,
        output ready
    );
endinterface : frx_out_if
`default_nettype wire

>>> hw/rtl/frx_flow_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frx_flow_table: flow table with parallel key match
// Holds key and expected sequence per slot; finds the matching slot and the
// lowest free slot combinationally and applies one update per cycle.
// ----------------------------------------------------------------------------
module frx_flow_table
    import frx_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire t_update          i_upd,
    output t_lookup               o_lookup
);

    logic                r_valid [FLOWS];
    logic [KEY_W-1:0]    r_key   [FLOWS];
    logic [SEQ_W-1:0]    r_exp   [FLOWS];

    // Match and free-slot search, lowest index wins
    always_comb begin
        o_lookup = '0;
        for (int i = FLOWS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_key)) begin
                o_lookup.hit      = 1'b1;
                o_lookup.hit_idx  = FLOW_W'(i);
                o_lookup.expected = r_exp[i];
            end
            if (!r_valid[i]) begin
                o_lookup.free_ok  = 1'b1;
                o_lookup.free_idx = FLOW_W'(i);
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FLOWS; i++) r_valid[i] <= 1'b0;
        end else if (i_upd.add) begin
            r_valid[i_upd.idx] <= 1'b1;
        end else if (i_upd.remove) begin
            r_valid[i_upd.idx] <= 1'b0;
        end
    end

    // Key and expected sequence storage
    always_ff @(posedge i_clk) begin
        if (i_upd.add) begin
            r_key[i_upd.idx] <= i_upd.key;
        end
        if (i_upd.add || i_upd.bump) begin
            r_exp[i_upd.idx] <= i_upd.expected;
        end
    end

endmodule : frx_flow_table
`default_nettype wire

>>> hw/rtl/frx_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frx_decide: per-packet reply decision
// Combines packet, table lookup and drop rate into the reply and the table
// update command.
// ----------------------------------------------------------------------------
module frx_decide
    import frx_pkg::*;
(
    input  wire t_item               i_item,
    input  wire t_lookup             i_lookup,
    input  wire logic [ROLL_W-1:0]   i_drop_rate,
    output t_result                  o_result,
    output t_update                  o_upd
);

    logic hit1;
    logic hit2;

    assign hit1 = i_item.first_roll  < i_drop_rate;
    assign hit2 = i_item.second_roll < i_drop_rate;

    always_comb begin
        o_result            = '0;
        o_result.reply_kind = RPL_NONE;
        o_result.event_code = EV_ERROR;
        o_upd               = '0;
        o_upd.key           = {i_item.client_address, i_item.client_port};
        o_upd.expected      = i_item.sequence_number;

        case (i_item.operation)
            // Flow registration
            OP_CTRL: begin
                if (hit1) begin
                    o_result.reply_kind = RPL_DROP;
                    o_result.event_code = EV_DROP_CTRL;
                end else if (i_item.target_fault) begin
                    o_result.event_code = EV_ERROR;
                end else if (i_lookup.hit || !i_lookup.free_ok) begin
                    o_result.reply_kind = RPL_DROP;
                    o_result.event_code = EV_DROP_CTRL;
                end else begin
                    o_upd.add = 1'b1;
                    o_upd.idx = i_lookup.free_idx;
                    if (hit2) begin
                        o_result.reply_kind = RPL_DROP;
                        o_result.event_code = EV_ACK_DROP;
                    end else begin
                        o_result.reply_kind = RPL_ACK;
                        o_result.event_code = EV_CTRL;
                    end
                end
            end
            // Data against expected sequence
            OP_DATA: begin
                if (!i_lookup.hit) begin
                    o_result.event_code = EV_DROP_DATA;
                end else if (hit1) begin
                    o_result.reply_kind = RPL_DROP;
                    o_result.event_code = EV_DROP_DATA;
                end else if (i_item.sequence_number < i_lookup.expected) begin
                    o_result.reply_kind = RPL_ACK;
                    o_result.ack_number = i_item.sequence_number;
                    o_result.event_code = EV_ACK_OLD;
                end else if (i_item.sequence_number != i_lookup.expected) begin
                    o_result.reply_kind = RPL_DROP;
                    o_result.event_code = EV_DROP_DATA;
                end else if (i_item.target_fault) begin
                    o_result.event_code = EV_ERROR;
                end else begin
                    o_result.data_accepted = 1'b1;
                    o_result.start_of_file = (i_item.sequence_number == '0);
                    // saturating advance
                    o_upd.bump     = (i_lookup.expected != SEQ_MAX);
                    o_upd.idx      = i_lookup.hit_idx;
                    o_upd.expected = i_lookup.expected + SEQ_W'(1);
                    if (hit2) begin
                        o_result.event_code = EV_ACK_DROP;
                    end else begin
                        o_result.reply_kind = RPL_ACK;
                        o_result.ack_number = i_item.sequence_number;
                        o_result.event_code = EV_DATA;
                    end
                end
            end
            // Flow removal
            OP_FIN: begin
                o_upd.remove        = i_lookup.hit;
                o_upd.idx           = i_lookup.hit_idx;
                o_result.event_code = EV_FIN;
            end
            default: begin
                o_result.event_code = EV_ERROR;
            end
        endcase
    end

endmodule : frx_decide
`default_nettype wire

>>> hw/rtl/flow_sequence_receiver.sv
// Path: a packet transaction loads the input register, then the result
//   register loads and raises reply valid; a reply held by back-pressure
//   stalls stage one until it drains.
// Throughput: one packet per cycle while replies are not held by back-pressure,
//   set by the flow table match and update between the two registers.
// Reset: synchronous, active low; clears drop rate, flow valid bits and both
//   pipeline valid flags. No clearing pass; a packet can follow reset at once.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flow_sequence_receiver: per-flow sequence tracking receiver
// Registers client flows, checks data sequence numbers against each flow's
// expected number and produces one reply per packet.
// ----------------------------------------------------------------------------
module flow_sequence_receiver
    import frx_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [ROLL_W-1:0] i_cfg_wr_data,
    frx_in_if.sink                 i_pkt,
    frx_out_if.source              o_res
);

    logic [ROLL_W-1:0] r_drop_rate;
    logic              r_s1_valid;
    t_item             r_s1_item;
    logic              r_out_valid;
    t_result           r_out;

    t_item             n_item;
    t_lookup           lookup;
    t_result           n_result;
    t_update           dec_upd;
    t_update           tbl_upd;
    logic              advance;
    logic              take;

    // Drop rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_rate <= '0;
        end else if (i_cfg_wr_en) begin
            r_drop_rate <= i_cfg_wr_data;
        end
    end

    // Handshake: stage one moves when the result register is free or drains
    assign advance     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pkt.ready = !r_s1_valid || advance;
    assign take        = i_pkt.valid && i_pkt.ready;

    assign n_item = '{operation:       i_pkt.operation,
                      client_address:  i_pkt.client_address,
                      client_port:     i_pkt.client_port,
                      sequence_number: i_pkt.sequence_number,
                      first_roll:      i_pkt.first_roll,
                      second_roll:     i_pkt.second_roll,
                      target_fault:    i_pkt.target_fault};

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pkt.ready) begin
            r_s1_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_item <= n_item;
        end
    end

    frx_flow_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    ({r_s1_item.client_address, r_s1_item.client_port}),
        .i_upd    (tbl_upd),
        .o_lookup (lookup)
    );

    frx_decide u_decide (
        .i_item      (r_s1_item),
        .i_lookup    (lookup),
        .i_drop_rate (r_drop_rate),
        .o_result    (n_result),
        .o_upd       (dec_upd)
    );

    // Table changes only when the packet retires into the result register
    always_comb begin
        tbl_upd        = dec_upd;
        tbl_upd.add    = dec_upd.add    && advance;
        tbl_upd.bump   = dec_upd.bump   && advance;
        tbl_upd.remove = dec_upd.remove && advance;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.reply_kind    = r_out.reply_kind;
    assign o_res.ack_number    = r_out.ack_number;
    assign o_res.data_accepted = r_out.data_accepted;
    assign o_res.start_of_file = r_out.start_of_file;
    assign o_res.event_code    = r_out.event_code;

`ifndef SYNTHESIS
    // Accepted payload only on data-accepted events
    a_acc_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.data_accepted) |->
            (r_out.event_code == EV_DATA || r_out.event_code == EV_ACK_DROP))
        else $error("data accepted with wrong event code");

    // Start of file implies accepted payload
    a_sof_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.start_of_file) |-> r_out.data_accepted)
        else $error("start of file without accepted data");

    // Non-ACK replies carry a zero number
    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reply_kind != RPL_ACK) |-> (r_out.ack_number == '0))
        else $error("ack number set on non-ACK reply");

    // Table never applies more than one of add, bump and remove in the same cycle
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({tbl_upd.add, tbl_upd.bump, tbl_upd.remove}) <= 1)
        else $error("conflicting flow table updates");
`endif

endmodule : flow_sequence_receiver
`default_nettype wire

>>> bench/flow_sequence_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_sequence_receiver_tb: self-checking bench for the flow sequence receiver
// Drives packets through the valid/ready input channel and predicts each reply
// from a flow table kept in the bench. Directed tests cover the registration,
// in-order, old, gap, fault, finish, table overflow and drop roll cases. Random
// traffic then runs under three idling mixes and several drop rates.
// ----------------------------------------------------------------------------
module flow_sequence_receiver_tb;
    import frx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL        = 24;
    localparam int PRINT_CAP   = 40;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [ROLL_W-1:0] i_cfg_wr_data;

    frx_in_if  pkt_if ();
    frx_out_if res_if ();

    flow_sequence_receiver DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pkt         (pkt_if),
        .o_res         (res_if)
    );

    // Predicted flow table and drop threshold
    logic              flow_live [FLOWS];
    logic [KEY_W-1:0]  flow_key  [FLOWS];
    logic [SEQ_W-1:0]  flow_next [FLOWS];
    logic [ROLL_W-1:0] drop_pct;

    // Replies still owed by the block, oldest first
    t_result           reply_q [$];
    logic [KEY_W-1:0]  key_pool [POOL];

    int error_count;
    int reply_count;
    int cycle_count;
    int send_gap_pct;
    int stall_pct;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Reply side back-pressure
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] MISMATCH reply %0d: %s", $realtime, reply_count, msg);
        error_count++;
    endtask

    function automatic int find_flow(input logic [KEY_W-1:0] key);
        for (int i = 0; i < FLOWS; i++)
            if (flow_live[i] && flow_key[i] == key)
                return i;
        return -1;
    endfunction

    // Reply prediction; updates the bench flow table as the block would
    function automatic t_result decide_reply(input t_item p);
        t_result          r;
        logic [KEY_W-1:0] key;
        logic             drop1;
        logic             drop2;
        int               slot;
        int               spare;
        r            = '0;
        r.reply_kind = RPL_NONE;
        r.event_code = EV_ERROR;
        key   = {p.client_address, p.client_port};
        drop1 = p.first_roll < drop_pct;
        drop2 = p.second_roll < drop_pct;
        slot  = find_flow(key);
        spare = -1;
        for (int i = FLOWS - 1; i >= 0; i--)
            if (!flow_live[i])
                spare = i;
        case (p.operation)
            OP_CTRL: begin
                if (drop1 || (!p.target_fault && (slot >= 0 || spare < 0))) begin
                    r.reply_kind = RPL_DROP;
                    r.event_code = EV_DROP_CTRL;
                end else if (!p.target_fault) begin
                    flow_live[spare] = 1'b1;
                    flow_key[spare]  = key;
                    flow_next[spare] = p.sequence_number;
                    r.reply_kind = drop2 ? RPL_DROP : RPL_ACK;
                    r.event_code = drop2 ? EV_ACK_DROP : EV_CTRL;
                end
            end
            OP_DATA: begin
                if (slot < 0) begin
                    r.event_code = EV_DROP_DATA;
                end else if (drop1) begin
                    r.reply_kind = RPL_DROP;
                    r.event_code = EV_DROP_DATA;
                end else if (p.sequence_number < flow_next[slot]) begin
                    r.reply_kind = RPL_ACK;
                    r.ack_number = p.sequence_number;
                    r.event_code = EV_ACK_OLD;
                end else if (p.sequence_number != flow_next[slot]) begin
                    r.reply_kind = RPL_DROP;
                    r.event_code = EV_DROP_DATA;
                end else if (!p.target_fault) begin
                    r.data_accepted = 1'b1;
                    r.start_of_file = (p.sequence_number == '0);
                    if (flow_next[slot] != SEQ_MAX)
                        flow_next[slot] = flow_next[slot] + 1'b1;
                    if (drop2) begin
                        r.event_code = EV_ACK_DROP;
                    end else begin
                        r.reply_kind = RPL_ACK;
                        r.ack_number = p.sequence_number;
                        r.event_code = EV_DATA;
                    end
                end
            end
            OP_FIN: begin
                if (slot >= 0)
                    flow_live[slot] = 1'b0;
                r.event_code = EV_FIN;
            end
            default: r.event_code = EV_ERROR;
        endcase
        return r;
    endfunction

    function automatic t_item make_packet(input logic [OP_W-1:0] op,
                                          input logic [KEY_W-1:0] key,
                                          input logic [SEQ_W-1:0] seq,
                                          input logic [ROLL_W-1:0] roll1,
                                          input logic [ROLL_W-1:0] roll2,
                                          input logic fault);
        t_item p;
        p.operation       = op;
        p.client_address  = key[KEY_W-1:PORT_W];
        p.client_port     = key[PORT_W-1:0];
        p.sequence_number = seq;
        p.first_roll      = roll1;
        p.second_roll     = roll2;
        p.target_fault    = fault;
        return p;
    endfunction

    // Random packet, mostly well-formed traffic on live flows
    function automatic t_item random_packet();
        t_item            p;
        logic [KEY_W-1:0] key;
        logic [SEQ_W-1:0] next;
        logic [OP_W-1:0]  op;
        int               pick;
        int               slot;
        int               start;
        logic             found;
        pick = $urandom_range(99);
        op   = (pick < 20) ? OP_CTRL : (pick < 80) ? OP_DATA : (pick < 92) ? OP_FIN : OP_UNK;
        key  = key_pool[$urandom_range(POOL - 1)];
        if ($urandom_range(99) < 5) begin
            key = {32'($urandom), 16'($urandom)};
        end else if (op == OP_DATA && $urandom_range(99) < 85) begin
            start = $urandom_range(FLOWS - 1);
            found = 1'b0;
            for (int i = 0; i < FLOWS; i++) begin
                if (!found && flow_live[(start + i) % FLOWS]) begin
                    key   = flow_key[(start + i) % FLOWS];
                    found = 1'b1;
                end
            end
        end
        slot = find_flow(key);
        next = (slot >= 0) ? flow_next[slot] : '0;
        pick = $urandom_range(99);
        p = make_packet(op, key, '0,
                        ($urandom_range(99) < 90) ? ROLL_W'($urandom_range(99))
                                                  : ROLL_W'($urandom_range(127)),
                        ($urandom_range(99) < 90) ? ROLL_W'($urandom_range(99))
                                                  : ROLL_W'($urandom_range(127)),
                        $urandom_range(99) < 6);
        if (op == OP_CTRL)
            p.sequence_number = (pick < 60) ? SEQ_W'($urandom_range(3)) :
                                (pick < 80) ? SEQ_MAX - SEQ_W'($urandom_range(3)) :
                                              SEQ_W'($urandom);
        else if (pick < 60)
            p.sequence_number = next;
        else if (pick < 75)
            p.sequence_number = (next == '0) ? next : SEQ_W'($urandom_range(next - 1));
        else if (pick < 88)
            p.sequence_number = next + SEQ_W'($urandom_range(1, 4));
        else
            p.sequence_number = SEQ_W'($urandom);
        return p;
    endfunction

    // Send one packet; called and returns at a falling edge
    task automatic send_packet(input t_item p);
        while ($urandom_range(99) < send_gap_pct) begin
            pkt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pkt_if.valid           <= 1'b1;
        pkt_if.operation       <= p.operation;
        pkt_if.client_address  <= p.client_address;
        pkt_if.client_port     <= p.client_port;
        pkt_if.sequence_number <= p.sequence_number;
        pkt_if.first_roll      <= p.first_roll;
        pkt_if.second_roll     <= p.second_roll;
        pkt_if.target_fault    <= p.target_fault;
        @(posedge i_clk);
        while (!pkt_if.ready)
            @(posedge i_clk);
        reply_q.push_back(decide_reply(p));
        @(negedge i_clk);
    endtask

    task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                        input logic [SEQ_W-1:0] seq, input logic fault = 1'b0,
                        input logic [ROLL_W-1:0] roll1 = 7'd99,
                        input logic [ROLL_W-1:0] roll2 = 7'd99);
        send_packet(make_packet(op, key, seq, roll1, roll2, fault));
    endtask

    // Drop threshold is only written with the pipeline drained
    task automatic set_drop_rate(input logic [ROLL_W-1:0] pct);
        pkt_if.valid <= 1'b0;
        while (reply_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= pct;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        drop_pct = pct;
    endtask

    // Reply checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (reply_q.size() == 0) begin
                report_mismatch($sformatf("unexpected reply kind %0d event %0d",
                                          res_if.reply_kind, res_if.event_code));
            end else begin
                want = reply_q.pop_front();
                if (res_if.reply_kind !== want.reply_kind)
                    report_mismatch($sformatf("reply_kind %0d, want %0d",
                                              res_if.reply_kind, want.reply_kind));
                if (res_if.ack_number !== want.ack_number)
                    report_mismatch($sformatf("ack_number %0h, want %0h",
                                              res_if.ack_number, want.ack_number));
                if (res_if.data_accepted !== want.data_accepted)
                    report_mismatch($sformatf("data_accepted %0b, want %0b",
                                              res_if.data_accepted, want.data_accepted));
                if (res_if.start_of_file !== want.start_of_file)
                    report_mismatch($sformatf("start_of_file %0b, want %0b",
                                              res_if.start_of_file, want.start_of_file));
                if (res_if.event_code !== want.event_code)
                    report_mismatch($sformatf("event_code %0d, want %0d",
                                              res_if.event_code, want.event_code));
            end
            reply_count++;
        end
    end

    // Registration, in-order, old, gap, fault, saturation, finish, unknown
    task automatic test_flow_lifecycle();
        send(OP_CTRL, key_pool[0], '0);                 // register, ACK 0
        send(OP_CTRL, key_pool[0], 31'd9);              // already present
        send(OP_DATA, key_pool[0], '0);                 // in order, start of file
        send(OP_DATA, key_pool[0], '0);                 // old, re-ack
        send(OP_DATA, key_pool[0], 31'd5);              // gap
        send(OP_DATA, key_pool[0], 31'd1, 1'b1);        // sink fault, no advance
        send(OP_DATA, key_pool[1], 31'd1);              // unregistered flow
        send(OP_CTRL, key_pool[1], '0, 1'b1);           // directory target
        send(OP_CTRL, key_pool[1], SEQ_MAX - 1'b1);
        send(OP_DATA, key_pool[1], SEQ_MAX - 1'b1);
        send(OP_DATA, key_pool[1], SEQ_MAX);            // expected saturates
        send(OP_DATA, key_pool[1], SEQ_MAX);            // still in order
        send(OP_UNK,  key_pool[1], SEQ_MAX, 1'b1, 7'd0, 7'd0);
        send(OP_FIN,  key_pool[0], '0);
        send(OP_FIN,  key_pool[0], '0);                 // absent flow
        send(OP_DATA, key_pool[0], 31'd1);              // flow gone
    endtask

    // Fill every slot, then one registration too many
    task automatic test_table_overflow();
        for (int i = 0; i < FLOWS; i++)
            if (i != 1)
                send(OP_CTRL, key_pool[i], SEQ_W'(i));
        send(OP_CTRL, key_pool[FLOWS], '0);
        send(OP_DATA, key_pool[FLOWS - 1], SEQ_W'(FLOWS - 1));
    endtask

    // Roll compare against the threshold, including out-of-range values
    task automatic test_drop_rolls();
        set_drop_rate(7'd100);
        send(OP_DATA, key_pool[1], SEQ_MAX, 1'b0, 7'd99, 7'd127);   // arrival drop
        send(OP_DATA, key_pool[1], SEQ_MAX, 1'b0, 7'd100, 7'd99);   // ack dropped
        send(OP_FIN,  key_pool[2], '0);
        send(OP_CTRL, key_pool[2], 31'd3, 1'b0, 7'd100, 7'd0);      // kept, reply dropped
        send(OP_CTRL, key_pool[FLOWS], '0, 1'b0, 7'd0, 7'd0);       // arrival drop
        set_drop_rate(7'd127);
        send(OP_DATA, key_pool[2], 31'd3, 1'b0, 7'd127, 7'd127);
        send(OP_DATA, key_pool[2], 31'd4, 1'b0, 7'd126, 7'd127);
        set_drop_rate(7'd0);
        send(OP_DATA, key_pool[2], 31'd4, 1'b0, 7'd0, 7'd0);
    endtask

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++)
            send_packet(random_packet());
    endtask

    // Random traffic under the three idling mixes
    task automatic test_random_traffic();
        send_gap_pct = 23;
        stall_pct    = 83;
        set_drop_rate(7'd10);
        random_burst(600);
        send_gap_pct = 83;
        stall_pct    = 23;
        set_drop_rate(7'd35);
        random_burst(600);
        send_gap_pct = 0;
        stall_pct    = 0;
        set_drop_rate(7'd0);
        random_burst(300);
        set_drop_rate(7'd5);
        random_burst(300);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        pkt_if.valid   = 1'b0;
        pkt_if.operation       = OP_CTRL;
        pkt_if.client_address  = '0;
        pkt_if.client_port     = '0;
        pkt_if.sequence_number = '0;
        pkt_if.first_roll      = '0;
        pkt_if.second_roll     = '0;
        pkt_if.target_fault    = 1'b0;
        res_if.ready   = 1'b0;
        error_count    = 0;
        reply_count    = 0;
        cycle_count    = 0;
        send_gap_pct   = 23;
        stall_pct      = 83;
        drop_pct       = '0;
        for (int i = 0; i < FLOWS; i++)
            flow_live[i] = 1'b0;

        // Extremes first, then random keys
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL; i++)
            key_pool[i] = {32'($urandom), 16'($urandom)};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_flow_lifecycle();
        test_table_overflow();
        test_drop_rolls();
        test_random_traffic();

        // Drain and give stray replies a chance to show up
        pkt_if.valid <= 1'b0;
        while (reply_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0 && reply_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule : flow_sequence_receiver_tb

>>> flow_sequence_receiver.f
hw/rtl/frx_pkg.sv
hw/rtl/frx_if.sv
hw/rtl/frx_flow_table.sv
hw/rtl/frx_decide.sv
hw/rtl/flow_sequence_receiver.sv
bench/flow_sequence_receiver_tb.sv
